FILE: rtl/core/rlzd_pkg.sv
// package for the resumable lz decompressor
// holds the state and parse phase types and format constants, no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rlzd_pkg;
  localparam int unsigned CntW = 30;
  localparam int unsigned LenW = 9;
  localparam int unsigned OffW = 12;
  localparam logic [3:0] LenExtCode = 4'd15;
  localparam logic [8:0] LenBase = 9'd3;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_PARSE = 5'b00010,
    ST_COPY  = 5'b00100,
    ST_WAIT  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    PH_ITEM = 2'd0,
    PH_OFF  = 2'd1,
    PH_EXT  = 2'd2
  } phase_t;
endpackage
`default_nettype wire

FILE: rtl/core/resumable_lz_decompressor_unit.sv
// top level of the resumable lz decompressor: parser, history window memory,
// output packer; depends on rlzd_pkg
//
// usage: write cfg_data (total raw length) while idle, then feed compressed
// bytes one per in word. each in word yields zero or more out words of up to
// BYTES_PER_RESULT bytes, out_last marks the final out word of an in word.
// after reset the window memory is cleared one entry per cycle; no input is
// taken during that sweep. a control byte or first tag byte is handled in the
// parse state alone, a literal in parse and then flush. an offset or extension
// byte that starts a match moves to copy; each copied byte then passes copy
// and wait, since each window read is registered and the next source address
// depends on the byte just written. each full out word inside the match takes
// an extra pass through copy, the match closes in copy and ends with a final
// flush. the output register holds a word while out_stall is high and the
// block waits for it to drain before continuing.
// bytes past the configured length are dropped and later input is ignored.
`timescale 1ns / 1ps
`default_nettype none
module resumable_lz_decompressor_unit #(
  parameter int unsigned WINDOW_SIZE      = 4096,
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_word,
  output logic [3:0]       out_count,
  output logic             out_last,
  output logic             out_full,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [29:0] cfg_data
);
  localparam int unsigned AW = $clog2(WINDOW_SIZE);
  localparam logic [3:0] BPR = 4'(BYTES_PER_RESULT);

  logic [7:0] mem [WINDOW_SIZE];
  logic [7:0] rd_q;
  logic [AW-1:0] wa, ra;
  logic [7:0] wd;
  logic we;

  rlzd_pkg::state_t st_r, st_nxt;
  rlzd_pkg::phase_t ph_r, ph_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [7:0] ctrl_r, ctrl_nxt;
  logic [3:0] cc_r, cc_nxt;
  logic [rlzd_pkg::LenW-1:0] len_r, len_nxt;
  logic [rlzd_pkg::OffW-1:0] off_r, off_nxt;
  logic [rlzd_pkg::CntW-1:0] bw_r, bw_nxt, olen_r;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0] ac_r, ac_nxt;
  logic ov_r, ov_nxt, ol_r, ol_nxt, of_r, of_nxt;
  logic [63:0] ow_r, ow_nxt;
  logic [3:0] oc_r, oc_nxt;

  logic full, obuf_free, take;
  logic [rlzd_pkg::CntW-1:0] bw_inc;
  logic [63:0] acc_put;
  logic [3:0] ac_put;

  assign full = bw_r >= olen_r;
  assign obuf_free = !ov_r || !out_stall;
  assign in_stall = !(st_r == rlzd_pkg::ST_PARSE && obuf_free);
  assign take = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign bw_inc = bw_r + 1'b1;
  assign out_valid = ov_r;
  assign out_word = ow_r;
  assign out_count = oc_r;
  assign out_last = ol_r;
  assign out_full = of_r;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; clr_nxt = clr_r; ctrl_nxt = ctrl_r; cc_nxt = cc_r;
    len_nxt = len_r; off_nxt = off_r; bw_nxt = bw_r; acc_nxt = acc_r; ac_nxt = ac_r;
    ov_nxt = ov_r && out_stall; ow_nxt = ow_r; oc_nxt = oc_r; ol_nxt = ol_r;
    of_nxt = of_r;
    we = 1'b0; wa = bw_r[AW-1:0]; wd = in_byte;
    ra = AW'(bw_r[AW-1:0] - off_r[AW-1:0]);
    acc_put = acc_r; ac_put = ac_r;
    case (st_r)
      rlzd_pkg::ST_CLEAR: begin
        we = 1'b1; wa = clr_r; wd = 8'd0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(WINDOW_SIZE - 1)) st_nxt = rlzd_pkg::ST_PARSE;
      end
      rlzd_pkg::ST_PARSE: begin
        if (take && !full) begin
          case (ph_r)
            rlzd_pkg::PH_OFF: begin
              off_nxt = off_r | {4'd0, in_byte};
              if (len_r == rlzd_pkg::LenBase + 9'(rlzd_pkg::LenExtCode)) begin
                ph_nxt = rlzd_pkg::PH_EXT;
              end else begin
                st_nxt = rlzd_pkg::ST_COPY;
              end
            end
            rlzd_pkg::PH_EXT: begin
              len_nxt = len_r + {1'b0, in_byte};
              st_nxt = rlzd_pkg::ST_COPY;
            end
            default: begin
              if (cc_r >= 4'd8) begin
                ctrl_nxt = in_byte; cc_nxt = 4'd0;
              end else if (ctrl_r[0]) begin
                len_nxt = {5'd0, in_byte[3:0]} + rlzd_pkg::LenBase;
                off_nxt = {in_byte[7:4], 8'd0};
                ph_nxt = rlzd_pkg::PH_OFF;
              end else begin
                we = 1'b1; bw_nxt = bw_inc;
                acc_nxt = acc_r | (64'(in_byte) << {ac_r[2:0], 3'b000});
                ac_nxt = ac_r + 1'b1;
                ctrl_nxt = ctrl_r >> 1; cc_nxt = cc_r + 1'b1;
                st_nxt = rlzd_pkg::ST_FLUSH;
              end
            end
          endcase
        end
      end
      rlzd_pkg::ST_COPY: begin
        if (len_r == '0 || full) begin
          ctrl_nxt = ctrl_r >> 1; cc_nxt = cc_r + 1'b1; ph_nxt = rlzd_pkg::PH_ITEM;
          st_nxt = rlzd_pkg::ST_FLUSH;
        end else if (ac_r >= BPR) begin
          if (obuf_free) begin
            ov_nxt = 1'b1; ow_nxt = acc_r; oc_nxt = ac_r; ol_nxt = 1'b0;
            of_nxt = full; acc_nxt = '0; ac_nxt = '0;
          end
        end else begin
          st_nxt = rlzd_pkg::ST_WAIT;
        end
      end
      rlzd_pkg::ST_WAIT: begin
        we = 1'b1; wd = rd_q; bw_nxt = bw_inc; len_nxt = len_r - 1'b1;
        acc_put = acc_r | (64'(rd_q) << {ac_r[2:0], 3'b000});
        ac_put = ac_r + 1'b1;
        acc_nxt = acc_put; ac_nxt = ac_put;
        st_nxt = rlzd_pkg::ST_COPY;
      end
      rlzd_pkg::ST_FLUSH: begin
        if (ac_r == '0) begin
          st_nxt = rlzd_pkg::ST_PARSE;
        end else if (obuf_free) begin
          ov_nxt = 1'b1; ow_nxt = acc_r; oc_nxt = ac_r; ol_nxt = 1'b1;
          of_nxt = full; acc_nxt = '0; ac_nxt = '0;
          st_nxt = rlzd_pkg::ST_PARSE;
        end
      end
      default: st_nxt = rlzd_pkg::ST_PARSE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rlzd_pkg::ST_CLEAR; ph_r <= rlzd_pkg::PH_ITEM; clr_r <= '0;
      ctrl_r <= '0; cc_r <= 4'd8; len_r <= '0; off_r <= '0; bw_r <= '0;
      acc_r <= '0; ac_r <= '0; ov_r <= 1'b0; olen_r <= '0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; clr_r <= clr_nxt; ctrl_r <= ctrl_nxt;
      cc_r <= cc_nxt; len_r <= len_nxt; off_r <= off_nxt; bw_r <= bw_nxt;
      acc_r <= acc_nxt; ac_r <= ac_nxt; ov_r <= ov_nxt;
      if (cfg_valid && cfg_ready) olen_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    ow_r <= ow_nxt; oc_r <= oc_nxt; ol_r <= ol_nxt; of_r <= of_nxt;
  end

  // no input during the clearing sweep
  a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == rlzd_pkg::ST_CLEAR |-> in_stall) else $error("input during clear");
  // packed count never exceeds one word
  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ac_r <= BPR) else $error("accumulator overflow");
  // the wait state, which consumes a copy read, always returns to copy next cycle
  a_copy_wait: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == rlzd_pkg::ST_WAIT |=> st_r == rlzd_pkg::ST_COPY) else $error("bad copy");
  // emitted words are never empty
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count != 4'd0) else $error("empty word");
endmodule
`default_nettype wire
